[rtl/core/lligr_pkg.sv]
// Shared types and constants for the linear layer input-gradient block.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package lligr_pkg;

    // default sizes of the stored matrix
    localparam int IN_MAX_DEF  = 64;
    localparam int OUT_MAX_DEF = 128;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [7:0] REG_IN_DIM  = 8'd0;
    localparam logic [7:0] REG_OUT_DIM = 8'd1;

    // register reset values
    localparam logic [6:0] IN_DIM_RESET  = 7'd64;
    localparam logic [7:0] OUT_DIM_RESET = 8'd128;

    // input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GRAD = 1'b1;

    // command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_GRAD = 2'd1,
        CMD_END  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        last;
        logic [5:0]  row;
        logic [6:0]  col;
        logic [31:0] value;
    } cmd_t;

    // clamped dimensions from the register file
    typedef struct packed {
        logic [6:0] n_in;
        logic [7:0] n_out;
    } dims_t;

endpackage

[rtl/core/linear_layer_input_gradient_top.sv]
// Top level of the linear layer input-gradient block.
// Depends on lligr_pkg, lligr_front, lligr_fifo and lligr_back.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_tvalid/s_tready   | tdata row,col,value; tlast; tuser opcode
//  m_      | out       | m_tvalid/m_tready   | tdata in_index,grad_in; tlast row_done
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A weight load is written while the back end is idle; a gradient element is issued
// index by index to the single shared fma pipeline, and the next element starts only
// once its fma results are written back. Each row result is read from memory before it leaves.
// Reset clears control state and the accumulator valid bits; weights are undefined
// until loaded. A four-entry queue lets input continue while results stall.
`timescale 1ns / 1ps

module linear_layer_input_gradient_top
    import lligr_pkg::*;
#(
    parameter int IN_MAX  = IN_MAX_DEF,
    parameter int OUT_MAX = OUT_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row_index[5:0], col_index[12:6], value_bits[44:13]
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // in_index[5:0], grad_in_bits[37:6]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic  push, full, pop, empty;
    cmd_t  push_cmd, pop_cmd;
    dims_t dims;

    lligr_front #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .dims      (dims)
    );

    lligr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    lligr_back #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dims     (dims),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/lligr_front.sv]
// Front end: configuration registers, input handshake and item classification.
// Depends on lligr_pkg; feeds lligr_fifo.
`timescale 1ns / 1ps

module lligr_front
    import lligr_pkg::*;
#(
    parameter int IN_MAX  = IN_MAX_DEF,
    parameter int OUT_MAX = OUT_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        full,
    output dims_t       dims
);

    logic [6:0]  in_dim_reg;
    logic [7:0]  out_dim_reg;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [31:0] value;
    logic        keep;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_dim_reg  <= IN_DIM_RESET;
            out_dim_reg <= OUT_DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_IN_DIM) begin
                in_dim_reg <= cfg_data[6:0];
            end else if (cfg_index == REG_OUT_DIM) begin
                out_dim_reg <= cfg_data;
            end
        end
    end

    // saturate dimensions to the stored matrix; zero is raised to one
    always_comb begin
        if (in_dim_reg == 7'd0) begin
            dims.n_in = 7'd1;
        end else if (32'(in_dim_reg) > IN_MAX) begin
            dims.n_in = 7'(IN_MAX);
        end else begin
            dims.n_in = in_dim_reg;
        end
        if (out_dim_reg == 8'd0) begin
            dims.n_out = 8'd1;
        end else if (32'(out_dim_reg) > OUT_MAX) begin
            dims.n_out = 8'(OUT_MAX);
        end else begin
            dims.n_out = out_dim_reg;
        end
    end

    assign row   = s_tdata[5:0];
    assign col   = s_tdata[12:6];
    assign value = s_tdata[44:13];

    // classify the item; dropped items need no back-end work
    always_comb begin
        keep           = 1'b0;
        push_cmd.kind  = CMD_LOAD;
        push_cmd.last  = s_tlast;
        push_cmd.row   = row;
        push_cmd.col   = col;
        push_cmd.value = value;
        if (s_tuser[0] == OP_LOAD) begin
            keep = (32'(row) < IN_MAX) && (32'(col) < OUT_MAX);
        end else if ({1'b0, col} < dims.n_out) begin
            keep          = 1'b1;
            push_cmd.kind = CMD_GRAD;
        end else if (s_tlast) begin
            keep          = 1'b1;
            push_cmd.kind = CMD_END;
        end
    end

    assign s_tready = !full;
    assign push     = s_tvalid && s_tready && keep;

endmodule

[rtl/core/lligr_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on lligr_pkg for the command type.
`timescale 1ns / 1ps

module lligr_fifo
    import lligr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (32'(count_reg) == DEPTH);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/lligr_fma.sv]
// Seven-stage single-precision fused multiply-add, round to nearest even.
// Self-contained; used by lligr_back, one operation accepted per cycle.
`timescale 1ns / 1ps

module lligr_fma #(
    parameter int TAG_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    input  logic [31:0]      c,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [31:0]      out_res,
    output logic [TAG_W-1:0] out_tag
);

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    function automatic logic [5:0] msb64(input logic [63:0] x);
        logic [5:0] k;
        k = 6'd0;
        for (int j = 0; j < 64; j++) begin
            if (x[j]) k = 6'(j);
        end
        return k;
    endfunction

    function automatic logic [63:0] shr_sticky(input logic [63:0] x, input logic [12:0] d);
        logic [63:0] mask;
        logic [63:0] res;
        mask = (64'd1 << d[5:0]) - 64'd1;
        if (d >= 13'd63) begin
            res = {63'd0, (x != 64'd0)};
        end else begin
            res = (x >> d[5:0]) | {63'd0, ((x & mask) != 64'd0)};
        end
        return res;
    endfunction

    logic [6:0] v_reg;
    logic [TAG_W-1:0] tag_reg [7];
    logic [6:0] spec_reg;
    logic [31:0] sval_reg [6];

    // stage 1 registers
    logic [47:0]        s1_p;
    logic signed [12:0] s1_pe, s1_ce;
    logic [23:0]        s1_mc;
    logic               s1_cz, s1_sp, s1_sc;
    // stage 2
    logic [63:0]        s2_p, s2_c;
    logic signed [12:0] s2_pe, s2_ce;
    logic               s2_cz, s2_sp, s2_sc;
    // stage 3
    logic [63:0]        s3_p, s3_c;
    logic signed [12:0] s3_e;
    logic               s3_sp, s3_sc;
    // stage 4
    logic [63:0]        s4_m;
    logic signed [12:0] s4_e;
    logic               s4_sr;
    // stage 5
    logic [63:0]        s5_m;
    logic signed [12:0] s5_q, s5_sh;
    logic               s5_sr;
    // stage 6
    logic [24:0]        s6_r;
    logic signed [12:0] s6_q;
    logic               s6_sr;
    // stage 7
    logic [31:0]        res_reg;

    // stage 1 decode
    logic       sa, sb, sc, sp, az, bz, cz, nan_in;
    logic [7:0] ea, eb, ec, ea_e, eb_e, ec_e;
    logic       spec1;
    logic [31:0] sval1;
    always_comb begin
        sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
        ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
        az = (ea == 8'd0) && (a[22:0] == 23'd0);
        bz = (eb == 8'd0) && (b[22:0] == 23'd0);
        cz = (ec == 8'd0) && (c[22:0] == 23'd0);
        ea_e = (ea == 8'd0) ? 8'd1 : ea;
        eb_e = (eb == 8'd0) ? 8'd1 : eb;
        ec_e = (ec == 8'd0) ? 8'd1 : ec;
        nan_in = ((ea == 8'hFF) && (a[22:0] != 23'd0)) || ((eb == 8'hFF) && (b[22:0] != 23'd0))
            || ((ec == 8'hFF) && (c[22:0] != 23'd0));
        spec1 = 1'b1;
        sval1 = QNAN;
        if (nan_in) begin
            sval1 = QNAN;
        end else if ((ea == 8'hFF) || (eb == 8'hFF)) begin
            if (az || bz) begin
                sval1 = QNAN;
            end else if ((ec == 8'hFF) && (sc != sp)) begin
                sval1 = QNAN;
            end else begin
                sval1 = {sp, 8'hFF, 23'd0};
            end
        end else if (ec == 8'hFF) begin
            sval1 = c;
        end else if (az || bz) begin
            sval1 = cz ? {(sp & sc), 31'd0} : c;
        end else begin
            spec1 = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        s1_p  <= {(ea != 8'd0), a[22:0]} * {(eb != 8'd0), b[22:0]};
        s1_pe <= $signed({5'd0, ea_e}) + $signed({5'd0, eb_e}) - 13'sd300;
        s1_mc <= {(ec != 8'd0), c[22:0]};
        s1_ce <= $signed({5'd0, ec_e}) - 13'sd150;
        s1_cz <= cz;
        s1_sp <= sp;
        s1_sc <= sc;
    end

    // stage 2: normalize product and addend to bit 61
    logic [5:0] kp, kc;
    always_comb begin
        kp = msb64({16'd0, s1_p});
        kc = msb64({40'd0, s1_mc});
    end

    always_ff @(posedge aclk) begin
        s2_p  <= {16'd0, s1_p} << (6'd61 - kp);
        s2_pe <= s1_pe - $signed({7'd0, 6'd61 - kp});
        s2_c  <= {40'd0, s1_mc} << (6'd61 - kc);
        s2_ce <= s1_ce - $signed({7'd0, 6'd61 - kc});
        s2_cz <= s1_cz;
        s2_sp <= s1_sp;
        s2_sc <= s1_sc;
    end

    // stage 3: align the smaller operand with sticky
    logic signed [12:0] diff;
    assign diff = s2_pe - s2_ce;
    always_ff @(posedge aclk) begin
        s3_sp <= s2_sp;
        if (s2_cz) begin
            s3_p  <= s2_p;
            s3_c  <= 64'd0;
            s3_e  <= s2_pe;
            s3_sc <= s2_sp;
        end else if (diff >= 13'sd0) begin
            s3_p  <= s2_p;
            s3_c  <= shr_sticky(s2_c, diff);
            s3_e  <= s2_pe;
            s3_sc <= s2_sc;
        end else begin
            s3_p  <= shr_sticky(s2_p, -diff);
            s3_c  <= s2_c;
            s3_e  <= s2_ce;
            s3_sc <= s2_sc;
        end
    end

    // stage 4: add or subtract magnitudes
    logic [63:0] m4;
    logic        sr4;
    always_comb begin
        if (s3_sp == s3_sc) begin
            m4 = s3_p + s3_c; sr4 = s3_sp;
        end else if (s3_p >= s3_c) begin
            m4 = s3_p - s3_c; sr4 = s3_sp;
        end else begin
            m4 = s3_c - s3_p; sr4 = s3_sc;
        end
    end

    always_ff @(posedge aclk) begin
        s4_m  <= m4;
        s4_e  <= s3_e;
        s4_sr <= sr4;
    end

    // stage 5: leading one and target exponent
    logic [5:0]         k5;
    logic signed [12:0] q5;
    always_comb begin
        k5 = msb64(s4_m);
        q5 = $signed({7'd0, k5}) + s4_e - 13'sd23;
        if (q5 < -13'sd149) q5 = -13'sd149;
    end

    always_ff @(posedge aclk) begin
        s5_m  <= s4_m;
        s5_q  <= q5;
        s5_sh <= q5 - s4_e;
        s5_sr <= s4_sr;
    end

    // stage 6: shift and round to nearest even
    logic [24:0]        r6;
    logic signed [12:0] lsh;
    logic [5:0]         s6s;
    logic [63:0]        rem, half, rs;
    logic               inc;
    always_comb begin
        lsh  = -s5_sh;
        s6s  = s5_sh[5:0];
        rs   = s5_m >> s6s;
        rem  = s5_m & ((64'd1 << s6s) - 64'd1);
        half = 64'd1 << (s6s - 6'd1);
        inc  = (rem > half) || ((rem == half) && rs[0]);
        if (s5_sh <= 13'sd0) begin
            r6 = 25'(s5_m << lsh[5:0]);
        end else if (s5_sh >= 13'sd64) begin
            r6 = 25'd0;
        end else begin
            r6 = 25'(rs) + {24'd0, inc};
        end
    end

    always_ff @(posedge aclk) begin
        s6_r  <= r6;
        s6_q  <= s5_q;
        s6_sr <= s5_sr;
    end

    // stage 7: carry-out fix and packing
    logic [24:0]        r7;
    logic signed [12:0] q7, biased;
    logic [31:0]        packed7;
    always_comb begin
        r7 = s6_r;
        q7 = s6_q;
        if (s6_r[24]) begin
            r7 = s6_r >> 1;
            q7 = s6_q + 13'sd1;
        end
        biased = q7 + 13'sd150;
        if (!r7[23]) begin
            packed7 = {s6_sr, 8'd0, r7[22:0]};
        end else if (biased >= 13'sd255) begin
            packed7 = {s6_sr, 8'hFF, 23'd0};
        end else begin
            packed7 = {s6_sr, biased[7:0], r7[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= spec_reg[5] ? sval_reg[5] : packed7;
    end

    // special-result bypass and tag alongside the datapath; exact zero joins at stage 4
    always_ff @(posedge aclk) begin
        spec_reg[0] <= spec1;
        sval_reg[0] <= sval1;
        tag_reg[0]  <= in_tag;
        for (int s = 1; s < 7; s++) begin
            tag_reg[s] <= tag_reg[s-1];
        end
        for (int s = 1; s < 6; s++) begin
            if (s == 3) begin
                spec_reg[s] <= spec_reg[s-1] || (m4 == 64'd0);
                sval_reg[s] <= spec_reg[s-1] ? sval_reg[s-1] : 32'd0;
            end else begin
                spec_reg[s] <= spec_reg[s-1];
                sval_reg[s] <= sval_reg[s-1];
            end
        end
        spec_reg[6] <= spec_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    assign out_valid = v_reg[6];
    assign out_res   = res_reg;
    assign out_tag   = tag_reg[6];

endmodule

[rtl/core/lligr_back.sv]
// Back end: weight memory, accumulator memory, issue sequencer and result output.
// Depends on lligr_pkg and lligr_fma; takes commands from lligr_fifo.
`timescale 1ns / 1ps

module lligr_back
    import lligr_pkg::*;
#(
    parameter int IN_MAX  = IN_MAX_DEF,
    parameter int OUT_MAX = OUT_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dims_t       dims,
    output logic        pop,
    input  cmd_t        pop_cmd,
    input  logic        empty,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    localparam int IW    = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int CW    = $clog2(IN_MAX + 1);
    localparam int WDEP  = IN_MAX * OUT_MAX;
    localparam int AW    = (WDEP > 1) ? $clog2(WDEP) : 1;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_ISSUE     = 6'b000010,
        ST_DRAIN     = 6'b000100,
        ST_EMIT_RD   = 6'b001000,
        ST_EMIT_CAP  = 6'b010000,
        ST_EMIT_WAIT = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pend_reg;
    logic [31:0]   grad_reg;
    logic [6:0]    col_reg;
    logic          last_reg;
    logic          iss_v_reg;
    logic [IW-1:0] iss_idx_reg;

    logic [31:0]   wmem [WDEP];
    logic [31:0]   wq_reg;
    logic [31:0]   amem [IN_MAX];
    logic [31:0]   aq_reg;
    logic          aqv_reg;
    logic [IN_MAX-1:0] acc_valid_reg;

    logic          out_valid_reg;
    logic [5:0]    out_idx_reg;
    logic [31:0]   out_val_reg;
    logic          out_last_reg;

    logic          wr_w;
    logic [AW-1:0] w_waddr, w_raddr;
    logic          issue, at_last, fma_v;
    logic [31:0]   fma_res;
    logic [IW-1:0] fma_tag;
    logic [31:0]   idx_ext;

    assign pop     = (state_reg == ST_IDLE) && !empty;
    assign wr_w    = pop && (pop_cmd.kind == CMD_LOAD);
    assign w_waddr = AW'(32'(pop_cmd.row) * OUT_MAX + 32'(pop_cmd.col));
    assign w_raddr = AW'(32'(idx_reg) * OUT_MAX + 32'(col_reg));
    assign issue   = (state_reg == ST_ISSUE);
    assign at_last = (32'(idx_reg) == 32'(dims.n_in) - 1);
    assign idx_ext = 32'(idx_reg);

    // weight memory
    always_ff @(posedge aclk) begin
        if (wr_w) begin
            wmem[w_waddr] <= pop_cmd.value;
        end
        wq_reg <= wmem[w_raddr];
    end

    // accumulator memory: read at the sequencer index, written back by the fma
    always_ff @(posedge aclk) begin
        if (fma_v) begin
            amem[fma_tag] <= fma_res;
        end
        aq_reg  <= amem[idx_reg];
        aqv_reg <= acc_valid_reg[idx_reg];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    case (pop_cmd.kind)
                        CMD_GRAD: begin
                            idx_next   = '0;
                            state_next = ST_ISSUE;
                        end
                        CMD_END: begin
                            idx_next   = '0;
                            state_next = ST_EMIT_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (at_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (pend_reg == '0) begin
                    idx_next   = '0;
                    state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD:  state_next = ST_EMIT_CAP;
            ST_EMIT_CAP: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (m_tready) begin
                    if (out_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= '0;
            iss_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            iss_v_reg <= issue;
            if (issue && !fma_v) begin
                pend_reg <= pend_reg + 1'b1;
            end else if (fma_v && !issue) begin
                pend_reg <= pend_reg - 1'b1;
            end
            if (state_reg == ST_EMIT_CAP) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (fma_v) begin
                acc_valid_reg[fma_tag] <= 1'b1;
            end
            if ((state_reg == ST_EMIT_WAIT) && m_tready && out_last_reg) begin
                acc_valid_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        iss_idx_reg <= idx_reg;
        if (pop && (pop_cmd.kind == CMD_GRAD)) begin
            grad_reg <= pop_cmd.value;
            col_reg  <= pop_cmd.col;
            last_reg <= pop_cmd.last;
        end else if (pop && (pop_cmd.kind == CMD_END)) begin
            last_reg <= 1'b1;
        end
        if (state_reg == ST_EMIT_CAP) begin
            out_idx_reg  <= idx_ext[5:0];
            out_val_reg  <= aqv_reg ? aq_reg : 32'd0;
            out_last_reg <= at_last;
        end
    end

    lligr_fma #(
        .TAG_W (IW)
    ) u_fma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (iss_v_reg),
        .a         (grad_reg),
        .b         (wq_reg),
        .c         (aqv_reg ? aq_reg : 32'd0),
        .in_tag    (iss_idx_reg),
        .out_valid (fma_v),
        .out_res   (fma_res),
        .out_tag   (fma_tag)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

[rtl/core/lligr_checker.sv]
// Port-level checks for the linear layer input-gradient block.
// Bound to linear_layer_input_gradient_top; sees only its ports.
`timescale 1ns / 1ps

module lligr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        s_tlast,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [7:0]  cfg_index,
    input logic [7:0]  cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // each result is read from memory again, so a transfer is followed by a gap
    a_out_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result shown without a fresh read");

    // no result in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind linear_layer_input_gradient_top lligr_checker u_lligr_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for linear_layer_input_gradient_top.
// Depends on lligr_pkg and the block's RTL; holds its own fused multiply-add predictor.
`timescale 1ns / 1ps

module tb_top;
    import lligr_pkg::*;

    localparam int N_ROWS     = 64;
    localparam int N_COLS     = 128;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [5:0]  idx;
        logic [31:0] grad;
        logic        done;
    } grad_result_t;

    typedef struct {
        logic        op;
        logic [5:0]  row;
        logic [6:0]  col;
        logic [31:0] val;
        logic        last;
        logic        has_exp;
        logic [31:0] exp0;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // shadow state of the block
    logic [31:0]  weights [N_ROWS][N_COLS];
    bit           loaded [N_ROWS][N_COLS];
    logic [31:0]  acc [N_ROWS];
    logic [6:0]   in_dim_reg = IN_DIM_RESET;
    logic [7:0]   out_dim_reg = OUT_DIM_RESET;
    grad_result_t pending_results[$];

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  rows_done = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    int  hold_req = 0;
    int  hold_left = 0;

    linear_layer_input_gradient_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // ---------------- single-precision fused multiply-add ----------------

    function automatic int top_bit(longint unsigned x);
        int k;
        k = 63;
        while (k > 0 && x[k] == 1'b0) k--;
        return k;
    endfunction

    function automatic longint unsigned shift_sticky(longint unsigned x, int d);
        longint unsigned mask;
        if (d <= 0) return x;
        if (d >= 63) return (x != 0) ? 64'd1 : 64'd0;
        mask = (64'd1 << d) - 64'd1;
        return (x >> d) | (((x & mask) != 0) ? 64'd1 : 64'd0);
    endfunction

    function automatic logic [31:0] fmadd32(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        logic sa, sb, sc, sp, sr;
        int ea, eb, ec, pe, ce, e_m, k, q, sh, biased;
        logic [22:0] fa, fb, fc;
        bit az, bz, cz;
        longint unsigned p, cm, m, r, rem, half;
        sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
        ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
        fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
        az = (ea == 0 && fa == 0); bz = (eb == 0 && fb == 0); cz = (ec == 0 && fc == 0);
        // specials: nan, infinities, zero factors
        if ((ea == 255 && fa != 0) || (eb == 255 && fb != 0) || (ec == 255 && fc != 0))
            return 32'h7FC00000;
        if (ea == 255 || eb == 255) begin
            if (az || bz) return 32'h7FC00000;
            if (ec == 255 && sc != sp) return 32'h7FC00000;
            return {sp, 31'h7F800000};
        end
        if (ec == 255) return c;
        if (az || bz) begin
            if (cz) return {sp & sc, 31'd0};
            return c;
        end
        // exact product, normalized with the top bit at 61
        p = longint'(ea != 0 ? {1'b1, fa} : {1'b0, fa}) *
            longint'(eb != 0 ? {1'b1, fb} : {1'b0, fb});
        pe = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 300;
        k = top_bit(p);
        p = p << (61 - k);
        pe = pe - (61 - k);
        if (cz) begin
            m = p; e_m = pe; sr = sp;
        end else begin
            cm = longint'(ec != 0 ? {1'b1, fc} : {1'b0, fc});
            ce = (ec != 0 ? ec : 1) - 150;
            k = top_bit(cm);
            cm = cm << (61 - k);
            ce = ce - (61 - k);
            if (pe >= ce) begin
                cm = shift_sticky(cm, pe - ce); e_m = pe;
            end else begin
                p = shift_sticky(p, ce - pe); e_m = ce;
            end
            if (sp == sc) begin
                m = p + cm; sr = sp;
            end else if (p >= cm) begin
                m = p - cm; sr = sp;
            end else begin
                m = cm - p; sr = sc;
            end
            // exact cancellation gives +0
            if (m == 0) return 32'd0;
        end
        // round to nearest even, subnormals kept
        k = top_bit(m);
        q = k + e_m - 23;
        if (q < -149) q = -149;
        sh = q - e_m;
        if (sh <= 0) begin
            r = m << (-sh);
        end else if (sh >= 64) begin
            r = 0;
        end else begin
            rem = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            r = m >> sh;
            if (rem > half || (rem == half && r[0])) r = r + 1;
        end
        if (r[24]) begin
            r = r >> 1; q = q + 1;
        end
        if (r >= 64'h800000) begin
            biased = q + 150;
            if (biased >= 255) return {sr, 31'h7F800000};
            return {sr, biased[7:0], r[22:0]};
        end
        return {sr, r[30:0]};
    endfunction

    // ---------------- predictor ----------------

    function automatic int eff_in_dim();
        if (in_dim_reg < 1) return 1;
        if (in_dim_reg > N_ROWS) return N_ROWS;
        return in_dim_reg;
    endfunction

    function automatic int eff_out_dim();
        if (out_dim_reg < 1) return 1;
        if (out_dim_reg > N_COLS) return N_COLS;
        return out_dim_reg;
    endfunction

    // update shadow state for one accepted input, queue any results; returns result 0
    function automatic logic [31:0] predict_grad(logic op, logic [5:0] row, logic [6:0] col,
                                                 logic [31:0] val, logic last);
        int n_in;
        grad_result_t res;
        logic [31:0] first;
        n_in = eff_in_dim();
        first = 'x;
        if (op == OP_LOAD) begin
            weights[row][col] = val;
            loaded[row][col] = 1'b1;
            return first;
        end
        if (col < eff_out_dim())
            for (int i = 0; i < n_in; i++) acc[i] = fmadd32(val, weights[i][col], acc[i]);
        if (!last) return first;
        first = acc[0];
        for (int i = 0; i < n_in; i++) begin
            res.idx = i[5:0];
            res.grad = acc[i];
            res.done = (i == n_in - 1);
            pending_results.push_back(res);
        end
        // the end of a row clears every accumulator
        for (int i = 0; i < N_ROWS; i++) acc[i] = 32'd0;
        rows_done++;
        return first;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_item(logic op, logic [5:0] row, logic [6:0] col, logic [31:0] val,
                             logic last, output logic [31:0] first);
        if (!calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, val, col, row};
        s_tlast  <= last;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        first = predict_grad(op, row, col, val, last);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // loads and open rows leave nothing to wait on, so let the queue and pipeline empty
        repeat (500) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] index, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_IN_DIM) in_dim_reg = data[6:0];
        else if (index == REG_OUT_DIM) out_dim_reg = data;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_float();
        int pick;
        pick = $urandom_range(99);
        if (pick < 78) return {1'($urandom_range(1)), 8'($urandom_range(140, 112)),
                               23'($urandom)};
        if (pick < 83) return {1'($urandom_range(1)), 31'd0};
        if (pick < 87) return {1'($urandom_range(1)), 31'h7F800000};
        if (pick < 89) return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(32'h7FFFFF, 1))};
        if (pick < 93) return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
        if (pick < 95) return {1'($urandom_range(1)), 31'h7F7FFFFF};
        return $urandom;
    endfunction

    function automatic bit column_ready(int c);
        for (int i = 0; i < eff_in_dim(); i++) if (!loaded[i][c]) return 1'b0;
        return 1'b1;
    endfunction

    // ---------------- result checking ----------------

    always @(posedge aclk) begin
        grad_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transfer, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[5:0] !== want.idx) begin
                        errors++;
                        $display("%0t: in_index expected %0d actual %0d",
                                 $time, want.idx, m_tdata[5:0]);
                    end
                    if (m_tdata[37:6] !== want.grad) begin
                        errors++;
                        $display("%0t: grad_in[%0d] expected %h actual %h",
                                 $time, want.idx, want.grad, m_tdata[37:6]);
                    end
                    if (m_tlast !== want.done) begin
                        errors++;
                        $display("%0t: row_done at %0d expected %b actual %b",
                                 $time, want.idx, want.done, m_tlast);
                    end
                end
            end
            // long hold-off on request, otherwise random stalls outside the calm phase
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    // small 2x2 matrix: exercises specials and extremes of the fields
    stim_row_t directed [] = '{
        '{OP_LOAD, 6'd0,  7'd0,   32'h3F800000, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD, 6'd1,  7'd0,   32'h40000000, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD, 6'd0,  7'd1,   32'h7F800000, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD, 6'd1,  7'd1,   32'h00000000, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD, 6'd63, 7'd127, 32'hFFFFFFFF, 1'b1, 1'b0, 32'h0},
        '{OP_GRAD, 6'd63, 7'd0,   32'h3F800000, 1'b1, 1'b1, 32'h3F800000},
        '{OP_GRAD, 6'd0,  7'd1,   32'h3F800000, 1'b1, 1'b1, 32'h7F800000},
        '{OP_GRAD, 6'd0,  7'd1,   32'h00000000, 1'b1, 1'b1, 32'h7FC00000},
        '{OP_GRAD, 6'd0,  7'd1,   32'hFFFFFFFF, 1'b1, 1'b1, 32'h7FC00000},
        '{OP_GRAD, 6'd0,  7'd127, 32'h3F800000, 1'b1, 1'b1, 32'h00000000},
        '{OP_GRAD, 6'd0,  7'd0,   32'h3F800000, 1'b0, 1'b0, 32'h0},
        '{OP_GRAD, 6'd0,  7'd0,   32'hBF800000, 1'b1, 1'b1, 32'h00000000},
        '{OP_GRAD, 6'd0,  7'd0,   32'h00000001, 1'b1, 1'b1, 32'h00000001},
        '{OP_GRAD, 6'd0,  7'd0,   32'h7F7FFFFF, 1'b0, 1'b0, 32'h0},
        '{OP_GRAD, 6'd0,  7'd0,   32'h7F7FFFFF, 1'b1, 1'b1, 32'h7F800000},
        '{OP_GRAD, 6'd0,  7'd0,   32'h80000001, 1'b1, 1'b1, 32'h80000001},
        '{OP_LOAD, 6'd0,  7'd0,   32'h00800000, 1'b0, 1'b0, 32'h0},
        '{OP_GRAD, 6'd0,  7'd0,   32'h80000001, 1'b1, 1'b1, 32'h80000000},
        '{OP_GRAD, 6'd0,  7'd0,   32'hBF000000, 1'b1, 1'b1, 32'h80400000},
        '{OP_LOAD, 6'd5,  7'd3,   32'h12345678, 1'b0, 1'b0, 32'h0},
        '{OP_GRAD, 6'd0,  7'd1,   32'h3F800000, 1'b0, 1'b0, 32'h0},
        '{OP_LOAD, 6'd0,  7'd1,   32'hFF800000, 1'b0, 1'b0, 32'h0},
        '{OP_GRAD, 6'd0,  7'd1,   32'h3F800000, 1'b1, 1'b1, 32'h7FC00000}
    };

    // register settings per phase: raw in_dim and out_dim writes, extremes included
    int phase_in []  = '{127, 1, 5, 0, 37, 64, 3};
    int phase_out [] = '{255, 0, 3, 17, 1, 128, 128};

    initial begin
        logic [31:0] first;
        int ready_cols[$];
        int want_cols, col, gi, n_in, n_out, order[$];
        for (int i = 0; i < N_ROWS; i++) begin
            acc[i] = 32'd0;
            for (int j = 0; j < N_COLS; j++) loaded[i][j] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        write_reg(REG_IN_DIM, 8'd2);
        write_reg(REG_OUT_DIM, 8'd2);
        foreach (directed[r]) begin
            send_item(directed[r].op, directed[r].row, directed[r].col, directed[r].val,
                      directed[r].last, first);
            if (directed[r].has_exp && first !== directed[r].exp0) begin
                errors++;
                $display("%0t: table row %0d grad_in[0] expected %h actual %h",
                         $time, r, directed[r].exp0, first);
            end
        end
        drain_results();

        // random phases, each at a new register setting
        foreach (phase_in[p]) begin
            write_reg(REG_IN_DIM, phase_in[p][7:0]);
            write_reg(REG_OUT_DIM, phase_out[p][7:0]);
            n_in = eff_in_dim();
            n_out = eff_out_dim();
            calm = (p == 2);
            // make sure some columns are fully loaded for the rows in use
            ready_cols.delete();
            for (int c = 0; c < n_out; c++) if (column_ready(c)) ready_cols.push_back(c);
            want_cols = (24 / n_in < 1) ? 1 : 24 / n_in;
            if (want_cols > n_out) want_cols = n_out;
            while (ready_cols.size() < want_cols) begin
                col = (p == 0) ? N_COLS - 1 : $urandom_range(n_out - 1);
                if (!column_ready(col)) begin
                    order.delete();
                    for (int i = 0; i < n_in; i++) order.push_back(i);
                    order.shuffle();
                    foreach (order[k])
                        send_item(OP_LOAD, order[k][5:0], col[6:0], rand_float(),
                                  1'($urandom_range(1)), first);
                    ready_cols.push_back(col);
                end
            end
            if (p == 0) hold_req = 400;
            // gradient rows with some stray loads and out-of-range columns
            for (gi = 0; gi < 16; gi++) begin
                if ($urandom_range(99) < 15) begin
                    col = $urandom_range(N_COLS - 1);
                    send_item(OP_LOAD, 6'($urandom), col[6:0], rand_float(),
                              1'($urandom_range(1)), first);
                    // a stray load into a partly loaded column keeps it unusable
                    continue;
                end
                if (n_out < N_COLS && $urandom_range(99) < 12)
                    col = $urandom_range(N_COLS - 1, n_out);
                else
                    col = ready_cols[$urandom_range(ready_cols.size() - 1)];
                send_item(OP_GRAD, 6'($urandom), col[6:0], rand_float(),
                          (gi == 15) || ($urandom_range(99) < 30), first);
            end
            calm = 1'b0;
            drain_results();
        end

        $display("covered %0d input items, %0d results over %0d rows, %0d register settings",
                 items_sent, results_seen, rows_done, phase_in.size() + 1);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
